[rtl/cbm_pkg.sv]
// ----------------------------------------------------------------------------
// cbm_pkg - cartridge bank mapper package
// Beat types, opcodes, result kinds and reset values shared by the mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int RAM_DEPTH = 128;

	localparam logic [1:0] OP_CPU_WR = 2'd0;
	localparam logic [1:0] OP_CPU_RD = 2'd1;
	localparam logic [1:0] OP_PPU    = 2'd2;

	localparam logic [2:0] KIND_RAM      = 3'd0;
	localparam logic [2:0] KIND_OPEN     = 3'd1;
	localparam logic [2:0] KIND_PRG      = 3'd2;
	localparam logic [2:0] KIND_CHR      = 3'd3;
	localparam logic [2:0] KIND_PAGE     = 3'd4;
	localparam logic [2:0] KIND_WROTE    = 3'd5;
	localparam logic [2:0] KIND_UNMAPPED = 3'd6;

	localparam logic [7:0] PRG0_RESET = 8'h00;
	localparam logic [7:0] PRG1_RESET = 8'h01;
	localparam logic [7:0] PRG2_RESET = 8'hFE;
	localparam logic [7:0] PRG_FIXED  = 8'hFF;

	localparam logic [15:0] ADDR_PAT_BASE = 16'h7EF0;
	localparam logic [15:0] ADDR_MIRROR   = 16'h7EF6;
	localparam logic [15:0] ADDR_PRG_BASE = 16'h7EFA;
	localparam logic [7:0]  ADDR_RAM_PAGE = 8'h7F;

	localparam logic [0:0] CFG_VARIANT = 1'b0;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  read_data;
		logic [20:0] rom_address;
		logic        nametable_page;
	} rsp_t;

	typedef struct packed {
		logic       pat_we;
		logic [2:0] pat_sel;
		logic       mir_we;
		logic       prg_we;
		logic [1:0] prg_sel;
		logic       ram_we;
	} wr_ctl_t;

endpackage

[rtl/cartridge_bank_mapper_with_ram.sv]
// Path: an accepted request beat passes the input register, decode and the
// output register; one beat per cycle unless rsp_stall holds the output.
// Internal RAM is read at accept with forwarding from the write in flight.
// Reset: bank registers to 00/01/FE and zero, mirroring and variant cleared.
// Internal RAM is not touched by reset and keeps its contents.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_ram - cartridge bank mapper top level
// Bank/mirroring registers, 128-byte internal RAM, APB variant register.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_ram #(
	parameter int RAM_DEPTH = cbm_pkg::RAM_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cbm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cbm_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int RAM_AW = $clog2(RAM_DEPTH);

	logic             valid_s1;
	cbm_pkg::req_t    req_s1;
	logic [7:0]       rdata_s1;
	logic             rsp_valid_q;
	cbm_pkg::rsp_t    rsp_q;
	logic [7:0]       prg_q [3];
	logic [7:0]       pat_q [6];
	logic             mirror_q;
	logic             variant_q;
	logic [7:0]       ram [RAM_DEPTH];
	cbm_pkg::rsp_t    rsp_d;
	cbm_pkg::wr_ctl_t wr;
	logic             adv;
	logic             fire;
	logic             accept;
	logic [RAM_AW-1:0] rd_idx;
	logic [RAM_AW-1:0] wr_idx;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign fire      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rd_idx    = req.address[RAM_AW-1:0];
	assign wr_idx    = req_s1.address[RAM_AW-1:0];

	cbm_xlate u_xlate (
		.req      (req_s1),
		.prg      (prg_q),
		.pat      (pat_q),
		.mirror   (mirror_q),
		.variant  (variant_q),
		.ram_data (rdata_s1),
		.rsp      (rsp_d),
		.wr       (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
			if (fire && wr.ram_we && wr_idx == rd_idx) begin
				rdata_s1 <= req_s1.write_data;
			end else begin
				rdata_s1 <= ram[rd_idx];
			end
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && wr.ram_we) begin
			ram[wr_idx] <= req_s1.write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_q[0] <= cbm_pkg::PRG0_RESET;
			prg_q[1] <= cbm_pkg::PRG1_RESET;
			prg_q[2] <= cbm_pkg::PRG2_RESET;
			for (int i = 0; i < 6; i++) begin
				pat_q[i] <= '0;
			end
			mirror_q <= 1'b0;
		end else if (fire) begin
			if (wr.pat_we) begin
				pat_q[wr.pat_sel] <= req_s1.write_data;
			end
			if (wr.mir_we) begin
				mirror_q <= req_s1.write_data[0];
			end
			if (wr.prg_we) begin
				prg_q[wr.prg_sel] <= req_s1.write_data;
			end
		end
	end

	// APB: one register, word 0
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cbm_pkg::CFG_VARIANT) ? {31'b0, variant_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == cbm_pkg::CFG_VARIANT) begin
			variant_q <= pwdata[0];
		end
	end

`ifndef SYNTHESIS
	a_stall_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && rsp_stall |-> req_stall)
		else $error("request not stalled while input stage blocked");

	a_rsp_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("result beat lost after stage advance");

	a_data_only_ram: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.result_kind != cbm_pkg::KIND_RAM |-> rsp_q.read_data == 8'h00)
		else $error("read_data nonzero on non-RAM result");

	a_rom_only_xlate: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.result_kind != cbm_pkg::KIND_PRG
		&& rsp_q.result_kind != cbm_pkg::KIND_CHR |-> rsp_q.rom_address == 21'd0)
		else $error("rom_address nonzero on non-ROM result");

	a_page_only_nt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.result_kind != cbm_pkg::KIND_PAGE |-> !rsp_q.nametable_page)
		else $error("nametable_page set on non-page result");
`endif

endmodule

[rtl/cbm_xlate.sv]
// ----------------------------------------------------------------------------
// cbm_xlate - access decode and address translation
// Turns one bus access into a result beat and register/RAM write strobes.
// ----------------------------------------------------------------------------
module cbm_xlate (
	input  cbm_pkg::req_t    req,
	input  logic [7:0]       prg [3],
	input  logic [7:0]       pat [6],
	input  logic             mirror,
	input  logic             variant,
	input  logic [7:0]       ram_data,
	output cbm_pkg::rsp_t    rsp,
	output cbm_pkg::wr_ctl_t wr
);

	logic [15:0] a;
	logic        in_window;
	logic [2:0]  slot;
	logic [2:0]  pat_idx;
	logic [1:0]  quad;
	logic [1:0]  prg_slot;
	logic [7:0]  bank;

	assign a         = req.address;
	assign in_window = a[15:13] == 3'b011;
	assign slot      = a[12:10];
	assign pat_idx   = slot - 3'd2;
	assign quad      = a[11:10];
	assign prg_slot  = a[14:13];
	assign bank      = (prg_slot == 2'd3) ? cbm_pkg::PRG_FIXED : prg[prg_slot];

	always_comb begin
		rsp = '0;
		rsp.result_kind = cbm_pkg::KIND_UNMAPPED;
		wr = '0;
		wr.pat_sel = a[2:0];
		wr.prg_sel = a[2:1] - 2'd1;
		unique case (req.opcode)
			cbm_pkg::OP_CPU_WR: begin
				if (in_window) begin
					rsp.result_kind = cbm_pkg::KIND_WROTE;
					if (a >= cbm_pkg::ADDR_PAT_BASE && a < cbm_pkg::ADDR_MIRROR) begin
						wr.pat_we = 1'b1;
					end else if (a == cbm_pkg::ADDR_MIRROR) begin
						wr.mir_we = 1'b1;
					end else if (a >= cbm_pkg::ADDR_PRG_BASE && a[15:8] == 8'h7E) begin
						wr.prg_we = 1'b1;
					end else if (a[15:8] == cbm_pkg::ADDR_RAM_PAGE) begin
						wr.ram_we = 1'b1;
					end
				end
			end
			cbm_pkg::OP_CPU_RD: begin
				if (a[15]) begin
					rsp.result_kind = cbm_pkg::KIND_PRG;
					rsp.rom_address = {bank, a[12:0]};
				end else if (a[15:8] == cbm_pkg::ADDR_RAM_PAGE) begin
					rsp.result_kind = cbm_pkg::KIND_RAM;
					rsp.read_data   = ram_data;
				end else if (in_window) begin
					rsp.result_kind = cbm_pkg::KIND_OPEN;
				end
			end
			cbm_pkg::OP_PPU: begin
				if (!a[13]) begin
					rsp.result_kind = cbm_pkg::KIND_CHR;
					if (!slot[2]) begin
						rsp.rom_address = {3'b000, pat[{2'b00, slot[1]}][7:1], a[10:0]};
					end else begin
						rsp.rom_address = {3'b000, pat[pat_idx], a[9:0]};
					end
				end else begin
					rsp.result_kind = cbm_pkg::KIND_PAGE;
					if (variant) begin
						rsp.nametable_page = pat[{2'b00, quad[1]}][7];
					end else if (mirror) begin
						rsp.nametable_page = quad[0];
					end else begin
						rsp.nametable_page = quad[1];
					end
				end
			end
			default: begin
				rsp.result_kind = cbm_pkg::KIND_UNMAPPED;
			end
		endcase
	end

endmodule
